>>> rtl/lsdrs_pkg.sv
`default_nettype none
package lsdrs_pkg;
	localparam int MAX_ITEMS = 64;
	localparam int DIGIT_BITS = 8;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 32;
	localparam int NUM_BUCKETS = 1 << DIGIT_BITS;
	localparam int NUM_PASSES = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int TOP_DIGIT_BITS = KEY_BITS - (NUM_PASSES - 1) * DIGIT_BITS;
	localparam int TOP_HALF = 1 << (TOP_DIGIT_BITS - 1);
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int BKT_W = DIGIT_BITS;
	localparam int PASS_W = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
	localparam int ENTRY_W = KEY_BITS + TAG_BITS;

	localparam logic REG_SIGNED = 1'b0;

	typedef enum logic [2:0] {
		DP_IDLE  = 3'd0,
		DP_CLEAR = 3'd1,
		DP_COUNT = 3'd2,
		DP_PREFIX = 3'd3,
		DP_PLACE = 3'd4,
		DP_EMIT  = 3'd5
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic             first;   // first step of a sweep
		logic [PASS_W-1:0] pass;
		logic             src_b;   // read from store b
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic emit_done;
	} dp_stat_t;
endpackage
`default_nettype wire

>>> rtl/lsdrs_datapath.sv
`default_nettype none
module lsdrs_datapath
	import lsdrs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	output dp_stat_t                 stat,
	input  wire logic                load_en,
	input  wire logic [KEY_BITS-1:0] load_key,
	input  wire logic [TAG_BITS-1:0] load_tag,
	input  wire logic [CNT_W-1:0]    count,
	input  wire logic                signed_keys,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic [KEY_BITS-1:0]      out_key,
	output logic [TAG_BITS-1:0]      out_tag,
	output logic                     out_last
);
	logic [ENTRY_W-1:0] store_a [MAX_ITEMS];
	logic [ENTRY_W-1:0] store_b [MAX_ITEMS];
	logic [CNT_W-1:0]   bucket_q [NUM_BUCKETS];

	logic [CNT_W-1:0]  idx_q;       // item index of the sweep
	logic [BKT_W:0]    bidx_q;      // bucket step of the clear and prefix sweeps
	logic [CNT_W-1:0]  acc_q;
	logic              rd_vld_s1;
	logic [CNT_W-1:0]  rd_idx_s1;
	logic [ENTRY_W-1:0] rd_a_s1, rd_b_s1;
	logic              src_b_s1;
	logic              vld_s2;      // bucket update pending
	logic [BKT_W-1:0]  bkt_s2;
	logic [ENTRY_W-1:0] ent_s2;
	logic [CNT_W-1:0]  bk_rd_s2;
	logic              wr_vld_q;
	logic [BKT_W-1:0]  wr_bkt_q;
	logic [CNT_W-1:0]  wr_val_q;
	logic [ENTRY_W-1:0] rd_ent;
	logic [BKT_W-1:0]  digit;
	logic [KEY_BITS-1:0] rd_key;
	logic [IDX_W-1:0]  rd_addr;
	logic [BKT_W-1:0]  pbkt;
	logic [BKT_W-1:0]  bk_raddr;
	logic [BKT_W-1:0]  bk_waddr;
	logic [CNT_W-1:0]  bk_wdata;
	logic [CNT_W-1:0]  bk_cur;
	logic              bk_we;
	logic              is_top;
	logic              last_rd;
	logic              out_free;
	logic              stall;
	logic              emit_take;

	assign out_free  = !out_valid || out_ready;
	assign stall     = (cmd.op == DP_EMIT) && rd_vld_s1 && !out_free;
	// hold the waiting entry by re-reading its address
	assign rd_addr   = stall ? rd_idx_s1[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign rd_ent    = src_b_s1 ? rd_b_s1 : rd_a_s1;
	assign rd_key    = rd_ent[ENTRY_W-1:TAG_BITS];
	assign is_top    = (cmd.pass == PASS_W'(NUM_PASSES - 1));
	assign digit     = BKT_W'(rd_key >> (cmd.pass * DIGIT_BITS));
	assign last_rd   = (idx_q == count);
	assign emit_take = (cmd.op == DP_EMIT) && !cmd.first && rd_vld_s1 && out_free;

	// signed top pass: visit the upper half of the top digit's buckets first
	assign pbkt = (signed_keys && is_top) ? (bidx_q[BKT_W-1:0] ^ BKT_W'(TOP_HALF))
		: bidx_q[BKT_W-1:0];
	assign bk_raddr = (cmd.op == DP_PREFIX) ? pbkt : digit;
	// forward the update written in the cycle this count was read
	assign bk_cur = (wr_vld_q && wr_bkt_q == bkt_s2) ? wr_val_q : bk_rd_s2;

	always_comb begin
		bk_we    = 1'b0;
		bk_waddr = bidx_q[BKT_W-1:0];
		bk_wdata = '0;
		case (cmd.op) inside
			DP_CLEAR: bk_we = !cmd.first && !bidx_q[BKT_W];
			DP_COUNT, DP_PLACE: begin
				bk_we    = vld_s2;
				bk_waddr = bkt_s2;
				bk_wdata = bk_cur + 1'b1;
			end
			DP_PREFIX: begin
				bk_we    = vld_s2;
				bk_waddr = bkt_s2;
				bk_wdata = acc_q;
			end
			default: ;
		endcase
	end

	// stores: one write port, one registered read port each
	always_ff @(posedge clk) begin
		rd_a_s1 <= store_a[rd_addr];
		rd_b_s1 <= store_b[rd_addr];
		if (load_en)
			store_a[count[IDX_W-1:0]] <= {load_key, load_tag};
		else if (cmd.op == DP_PLACE && vld_s2) begin
			if (cmd.src_b)
				store_a[bk_cur[IDX_W-1:0]] <= ent_s2;
			else
				store_b[bk_cur[IDX_W-1:0]] <= ent_s2;
		end
	end

	always_ff @(posedge clk) begin
		bk_rd_s2 <= bucket_q[bk_raddr];
		if (bk_we)
			bucket_q[bk_waddr] <= bk_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			bidx_q    <= '0;
			acc_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			src_b_s1  <= 1'b0;
			vld_s2    <= 1'b0;
			bkt_s2    <= '0;
			ent_s2    <= '0;
			wr_vld_q  <= 1'b0;
			wr_bkt_q  <= '0;
			wr_val_q  <= '0;
			out_valid <= 1'b0;
			out_key   <= '0;
			out_tag   <= '0;
			out_last  <= 1'b0;
		end else begin
			src_b_s1 <= cmd.src_b;
			bkt_s2   <= bk_raddr;
			ent_s2   <= rd_ent;
			wr_vld_q <= bk_we && (cmd.op == DP_COUNT || cmd.op == DP_PLACE);
			wr_bkt_q <= bk_waddr;
			wr_val_q <= bk_wdata;
			if (emit_take)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (emit_take) begin
				out_key  <= rd_key;
				out_tag  <= rd_ent[TAG_BITS-1:0];
				out_last <= (rd_idx_s1 + 1'b1 == count);
			end
			if (cmd.first) begin
				idx_q     <= '0;
				bidx_q    <= '0;
				acc_q     <= '0;
				rd_vld_s1 <= 1'b0;
				vld_s2    <= 1'b0;
			end else begin
				case (cmd.op) inside
					DP_IDLE: begin
						rd_vld_s1 <= 1'b0;
						vld_s2    <= 1'b0;
					end
					DP_CLEAR: bidx_q <= bidx_q + 1'b1;
					DP_PREFIX: begin
						if (!bidx_q[BKT_W])
							bidx_q <= bidx_q + 1'b1;
						vld_s2 <= !bidx_q[BKT_W];
						if (vld_s2)
							acc_q <= acc_q + bk_rd_s2;
					end
					DP_COUNT, DP_PLACE: begin
						rd_vld_s1 <= !last_rd;
						vld_s2    <= rd_vld_s1;
						if (!last_rd)
							idx_q <= idx_q + 1'b1;
					end
					DP_EMIT: begin
						// issue a read when the output slot frees up or no read is waiting
						if (out_free || !rd_vld_s1) begin
							rd_vld_s1 <= !last_rd;
							rd_idx_s1 <= idx_q;
							if (!last_rd)
								idx_q <= idx_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		stat.sweep_done = 1'b0;
		stat.emit_done  = 1'b0;
		case (cmd.op) inside
			DP_CLEAR:  stat.sweep_done = !cmd.first &&
				(bidx_q == (BKT_W+1)'(NUM_BUCKETS - 1));
			DP_PREFIX: stat.sweep_done = !cmd.first && bidx_q[BKT_W] && !vld_s2;
			DP_COUNT, DP_PLACE: stat.sweep_done = !cmd.first && last_rd && !rd_vld_s1 &&
				!vld_s2;
			DP_EMIT:   stat.emit_done = !cmd.first && last_rd && !rd_vld_s1 && out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/lsdrs_ctrl.sv
`default_nettype none
module lsdrs_ctrl
	import lsdrs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_fire,
	input  wire logic   in_last,
	input  wire logic [CNT_W-1:0] count,
	input  wire dp_stat_t stat,
	output dp_cmd_t     cmd,
	output logic        idle
);
	typedef enum logic [5:0] {
		S_LOAD   = 6'b000001,
		S_CLEAR  = 6'b000010,
		S_COUNT  = 6'b000100,
		S_PREFIX = 6'b001000,
		S_PLACE  = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q;
	logic   first_q;
	logic [PASS_W-1:0] pass_q;

	assign idle = (state_q == S_LOAD);

	always_comb begin
		cmd.first = first_q;
		cmd.pass  = pass_q;
		cmd.src_b = pass_q[0];
		unique case (state_q)
			S_LOAD:   cmd.op = DP_IDLE;
			S_CLEAR:  cmd.op = DP_CLEAR;
			S_COUNT:  cmd.op = DP_COUNT;
			S_PREFIX: cmd.op = DP_PREFIX;
			S_PLACE:  cmd.op = DP_PLACE;
			S_EMIT: begin
				cmd.op = DP_EMIT;
				cmd.src_b = (NUM_PASSES % 2) != 0;
			end
			default:  cmd.op = DP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			first_q <= 1'b0;
			pass_q  <= '0;
		end else begin
			first_q <= 1'b0;
			unique case (state_q)
				S_LOAD: if (in_fire && in_last) begin
					state_q <= S_CLEAR;
					first_q <= 1'b1;
					pass_q  <= '0;
				end
				S_CLEAR: if (stat.sweep_done) begin
					state_q <= S_COUNT;
					first_q <= 1'b1;
				end
				S_COUNT: if (stat.sweep_done) begin
					state_q <= S_PREFIX;
					first_q <= 1'b1;
				end
				S_PREFIX: if (stat.sweep_done) begin
					state_q <= S_PLACE;
					first_q <= 1'b1;
				end
				S_PLACE: if (stat.sweep_done) begin
					first_q <= 1'b1;
					if (pass_q == PASS_W'(NUM_PASSES - 1))
						state_q <= S_EMIT;
					else begin
						state_q <= S_CLEAR;
						pass_q  <= pass_q + 1'b1;
					end
				end
				S_EMIT: if (stat.emit_done || count == '0)
					state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/lsd_radix_sort_key_tag_top.sv
// LSD radix sort of key/tag items: four 8-bit digit passes ping-ponging two item stores.
// Loading accepts one item per cycle. After the last item each pass clears the 256 buckets,
// counts the N items into them, sweeps the 256 buckets for prefix sums and places the items.
// Emission then sends the N sorted items, holding on m_tready; the clear and prefix sweeps
// dominate the sort time. s_tready is low from the last item on.
// Reset is asynchronous, active low: control clears, signed_keys returns to 1.
`default_nettype none
module lsd_radix_sort_key_tag_top
	import lsdrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // key[31:0], tag[63:32]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // sorted_key[31:0], sorted_tag[63:32]
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic idle, in_fire, load_en, signed_q;
	logic [CNT_W-1:0] count_q;

	assign pready   = 1'b1;
	assign prdata   = (paddr == REG_SIGNED) ? {31'b0, signed_q} : 32'b0;
	assign s_tready = idle;
	assign in_fire  = s_tvalid && s_tready;
	assign load_en  = in_fire && (count_q < CNT_W'(MAX_ITEMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b1;
			count_q  <= '0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_SIGNED)
				signed_q <= pwdata[0];
			// clear the count when the sorted set has gone out or the set is empty
			if (cmd.op == DP_EMIT && (stat.emit_done || count_q == '0))
				count_q <= '0;
			else if (load_en)
				count_q <= count_q + 1'b1;
		end
	end

	lsdrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_tlast),
		.count(count_q), .stat(stat), .cmd(cmd), .idle(idle)
	);

	lsdrs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.load_en(load_en), .load_key(s_tdata[31:0]), .load_tag(s_tdata[63:32]),
		.count(count_q), .signed_keys(signed_q), .out_ready(m_tready),
		.out_valid(m_tvalid), .out_key(m_tdata[31:0]), .out_tag(m_tdata[63:32]),
		.out_last(m_tlast)
	);
endmodule
`default_nettype wire
